FILE: rtl/ptc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ptc_pkg;

   localparam int unsigned NUM_REGS    = 6;
   localparam int unsigned LATENCY     = 84;
   localparam logic [32:0] TF_OFFSET   = 33'd128000;
   localparam logic [20:0] P_FULLSCALE = 21'd1048576;
   localparam logic [16:0] P_SCALE     = 17'd3125;
   localparam int unsigned SH_ONE      = 47;
   localparam int unsigned SH_P4       = 35;
   localparam int unsigned SH_P1       = 33;
   localparam int unsigned SH_P5       = 17;

   typedef enum logic [2:0] {
      REG_T1_T2 = 3'd0,
      REG_T3_P1 = 3'd1,
      REG_P2_P3 = 3'd2,
      REG_P4_P5 = 3'd3,
      REG_P6_P7 = 3'd4,
      REG_P8_P9 = 3'd5
   } reg_index_type;

   // lower-word partial product, x times a signed 17-bit coefficient, x taken unsigned, sign-extended to 64 bits
   function automatic logic [63:0] pp_lo(input logic [31:0] x, input logic signed [16:0] c);
      logic signed [49:0] m;
      m = $signed({1'b0, x}) * c;
      return {{14{m[49]}}, m};
   endfunction

   // upper-word partial product, only its low 32 bits reach a 64-bit result
   function automatic logic [31:0] pp_hi(input logic [31:0] x, input logic signed [16:0] c);
      logic [31:0] m;
      m = x * {{15{c[16]}}, c};
      return m;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/pressure_temperature_compensation.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   | ports                                         | transfer
// ----------+-----------------------------------------------+---------------------------
// request   | start, busy, req_raw_temperature/pressure     | start high, busy low
// response  | rsp_valid, rsp_temperature_centi/pressure_pa  | rsp_valid high, one cycle
// csr       | csr_write_enable, csr_index, csr_write_data   | csr_write_enable high
//
// One transfer per cycle; results leave in the order of their requests.
// The pipeline holds the 64-stage restoring divider plus 20 arithmetic stages.
// Synchronous reset clears the coefficients and the stage valid bits.
// busy stays low; the receiver cannot stall, so the pipeline never holds.
module pressure_temperature_compensation
   import ptc_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  wire  [19:0]        req_raw_temperature,
   input  wire  [19:0]        req_raw_pressure,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_temperature_centi,
   output logic [31:0]        rsp_pressure_pa,
   input  wire                csr_write_enable,
   input  wire  [2:0]         csr_index,
   input  wire  [31:0]        csr_write_data
);

   logic [31:0] csr_ff [NUM_REGS];

   logic [15:0]        t1;
   logic signed [15:0] t2, t3;
   logic [15:0]        p1;
   logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

   assign t1 = csr_ff[REG_T1_T2][15:0];
   assign t2 = $signed(csr_ff[REG_T1_T2][31:16]);
   assign t3 = $signed(csr_ff[REG_T3_P1][15:0]);
   assign p1 = csr_ff[REG_T3_P1][31:16];
   assign p2 = $signed(csr_ff[REG_P2_P3][15:0]);
   assign p3 = $signed(csr_ff[REG_P2_P3][31:16]);
   assign p4 = $signed(csr_ff[REG_P4_P5][15:0]);
   assign p5 = $signed(csr_ff[REG_P4_P5][31:16]);
   assign p6 = $signed(csr_ff[REG_P6_P7][15:0]);
   assign p7 = $signed(csr_ff[REG_P6_P7][31:16]);
   assign p8 = $signed(csr_ff[REG_P8_P9][15:0]);
   assign p9 = $signed(csr_ff[REG_P8_P9][31:16]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) csr_ff[i] <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_T1_T2: csr_ff[REG_T1_T2] <= csr_write_data;
            REG_T3_P1: csr_ff[REG_T3_P1] <= csr_write_data;
            REG_P2_P3: csr_ff[REG_P2_P3] <= csr_write_data;
            REG_P4_P5: csr_ff[REG_P4_P5] <= csr_write_data;
            REG_P6_P7: csr_ff[REG_P6_P7] <= csr_write_data;
            REG_P8_P9: csr_ff[REG_P8_P9] <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // stage valid bits
   logic [LATENCY-1:0] vld_ff, vld_in;
   assign vld_in = {vld_ff[LATENCY-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // temperature path
   logic [31:0]        x1_ff, x1_in;
   logic signed [16:0] d_ff, d_in;
   logic [31:0]        aprod_ff, dd_ff, a_ff, dd2_ff, fine_ff;
   logic signed [47:0] aprod_m, dd2_m;
   logic signed [33:0] dd_m;
   logic [31:0]        fine_in, t5, temp_in;
   logic [32:0]        v1_ff, v1_in;

   assign x1_in = {15'd0, req_raw_temperature[19:3]} - {15'd0, t1, 1'b0};
   assign d_in  = $signed({1'b0, req_raw_temperature[19:4]} - {1'b0, t1});
   assign aprod_m = $signed(x1_ff) * t2;
   assign dd_m    = d_ff * d_ff;
   assign dd2_m   = ($signed(dd_ff) >>> 12) * t3;
   assign fine_in = a_ff + 32'($signed(dd2_ff) >>> 14);
   assign t5      = {fine_ff[29:0], 2'b00} + fine_ff + 32'd128;
   assign temp_in = 32'($signed(t5) >>> 8);
   assign v1_in   = {fine_ff[31], fine_ff} - TF_OFFSET;

   always_ff @(posedge clock) begin
      x1_ff    <= x1_in;
      d_ff     <= d_in;
      aprod_ff <= aprod_m[31:0];
      dd_ff    <= dd_m[31:0];
      a_ff     <= 32'($signed(aprod_ff) >>> 11);
      dd2_ff   <= dd2_m[31:0];
      fine_ff  <= fine_in;
      v1_ff    <= v1_in;
   end

   // raw pressure, stages 0..8
   logic [19:0] adp_ff [9];
   always_ff @(posedge clock) begin
      adp_ff[0] <= req_raw_pressure;
      for (int i = 1; i < 9; i++) adp_ff[i] <= adp_ff[i-1];
   end

   // temperature result, stages 4..83
   logic [31:0] tmp_ff [4:LATENCY-1];
   always_ff @(posedge clock) begin
      tmp_ff[4] <= temp_in;
      for (int i = 5; i < LATENCY; i++) tmp_ff[i] <= tmp_ff[i-1];
   end

   // pressure coefficients
   logic signed [65:0] sq_m;
   logic signed [48:0] m5_m, m2_m;
   logic [63:0] sq_ff;
   logic [48:0] m5_ff, m2_ff, m5b_ff, m2b_ff, m5c_ff, m2c_ff;
   logic [63:0] s6lo_ff, s3lo_ff;
   logic [31:0] s6hi_ff, s3hi_ff;
   logic [63:0] sqp6_ff, sqp3_ff, v2_ff, v1w_ff;
   logic [63:0] v2_in, v1w_in;
   logic [63:0] c1lo_ff, v1d_ff, diff_ff, diff_in, nlo_ff, numer_ff;
   logic [31:0] c1hi_ff, nhi_ff;
   logic [20:0] pf;
   logic [30:0] den_ff;

   assign sq_m = $signed(v1_ff) * $signed(v1_ff);
   assign m5_m = $signed(v1_ff) * p5;
   assign m2_m = $signed(v1_ff) * p2;
   assign v2_in = sqp6_ff + ({{15{m5c_ff[48]}}, m5c_ff} << SH_P5)
                + ({{48{p4[15]}}, p4} << SH_P4);
   assign v1w_in = 64'($signed(sqp3_ff) >>> 8) + ({{15{m2c_ff[48]}}, m2c_ff} << 12)
                 + (64'd1 << SH_ONE);
   assign pf = P_FULLSCALE - {1'b0, adp_ff[8]};
   assign diff_in = ({43'd0, pf} << 31) - v2_ff;

   always_ff @(posedge clock) begin
      sq_ff    <= sq_m[63:0];
      m5_ff    <= m5_m;
      m2_ff    <= m2_m;
      s6lo_ff  <= pp_lo(sq_ff[31:0], {p6[15], p6});
      s6hi_ff  <= pp_hi(sq_ff[63:32], {p6[15], p6});
      s3lo_ff  <= pp_lo(sq_ff[31:0], {p3[15], p3});
      s3hi_ff  <= pp_hi(sq_ff[63:32], {p3[15], p3});
      m5b_ff   <= m5_ff;
      m2b_ff   <= m2_ff;
      sqp6_ff  <= s6lo_ff + {s6hi_ff, 32'd0};
      sqp3_ff  <= s3lo_ff + {s3hi_ff, 32'd0};
      m5c_ff   <= m5b_ff;
      m2c_ff   <= m2b_ff;
      v2_ff    <= v2_in;
      v1w_ff   <= v1w_in;
      c1lo_ff  <= pp_lo(v1w_ff[31:0], $signed({1'b0, p1}));
      c1hi_ff  <= pp_hi(v1w_ff[63:32], $signed({1'b0, p1}));
      diff_ff  <= diff_in;
      v1d_ff   <= c1lo_ff + {c1hi_ff, 32'd0};
      nlo_ff   <= pp_lo(diff_ff[31:0], $signed(P_SCALE));
      nhi_ff   <= pp_hi(diff_ff[63:32], $signed(P_SCALE));
      den_ff   <= v1d_ff[SH_P1 +: 31];
      numer_ff <= nlo_ff + {nhi_ff, 32'd0};
   end

   // divider: magnitudes at stage 12, one quotient bit per stage after it
   localparam int unsigned DIV_STEPS = 64;
   logic [30:0] rem_ff [DIV_STEPS+1];
   logic [63:0] nq_ff  [DIV_STEPS+1];
   logic [30:0] md_ff  [DIV_STEPS+1];
   logic        neg_ff [DIV_STEPS+1];
   logic        zero_in;

   assign zero_in = (den_ff == '0);

   always_ff @(posedge clock) begin
      rem_ff[0] <= '0;
      nq_ff[0]  <= numer_ff[63] ? (64'd0 - numer_ff) : numer_ff;
      md_ff[0]  <= den_ff[30] ? (31'd0 - den_ff) : den_ff;
      neg_ff[0] <= numer_ff[63] ^ den_ff[30];
   end

   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
      logic [31:0] trial;
      logic [31:0] diff;
      logic        take;
      assign trial = {rem_ff[k-1], nq_ff[k-1][63]};
      assign diff  = trial - {1'b0, md_ff[k-1]};
      assign take  = (trial >= {1'b0, md_ff[k-1]});
      always_ff @(posedge clock) begin
         rem_ff[k] <= take ? diff[30:0] : trial[30:0];
         nq_ff[k]  <= {nq_ff[k-1][62:0], take};
         md_ff[k]  <= md_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
      end
   end

   // zero-divisor flag, stages 12..83
   logic zr_ff [12:LATENCY-1];
   always_ff @(posedge clock) begin
      zr_ff[12] <= zero_in;
      for (int i = 13; i < LATENCY; i++) zr_ff[i] <= zr_ff[i-1];
   end

   // pressure tail
   logic [63:0] pq_ff, pqa_ff, pqb_ff, pqc_ff, pqd_ff, q;
   logic [63:0] qll_ff, qq_ff, p8lo_ff, p8p_ff, q9lo_ff, v2f_ff, v2g_ff, v1f_ff, sum_ff;
   logic [31:0] qlh_ff, p8hi_ff, q9hi_ff;
   logic [63:0] qlh_m, pp_in;
   logic [31:0] pres_ff;

   assign q     = 64'($signed(pq_ff) >>> 13);
   assign qlh_m = 64'(q[31:0]) * 64'(q[63:32]);
   assign pp_in = 64'($signed(sum_ff) >>> 8) + ({{48{p7[15]}}, p7} << 4);

   always_ff @(posedge clock) begin
      pq_ff   <= neg_ff[DIV_STEPS] ? (64'd0 - nq_ff[DIV_STEPS]) : nq_ff[DIV_STEPS];
      qll_ff  <= 64'(q[31:0]) * 64'(q[31:0]);
      qlh_ff  <= qlh_m[31:0];
      p8lo_ff <= pp_lo(pq_ff[31:0], {p8[15], p8});
      p8hi_ff <= pp_hi(pq_ff[63:32], {p8[15], p8});
      pqa_ff  <= pq_ff;
      qq_ff   <= qll_ff + {qlh_ff[30:0], 33'd0};
      p8p_ff  <= p8lo_ff + {p8hi_ff, 32'd0};
      pqb_ff  <= pqa_ff;
      q9lo_ff <= pp_lo(qq_ff[31:0], {p9[15], p9});
      q9hi_ff <= pp_hi(qq_ff[63:32], {p9[15], p9});
      v2f_ff  <= 64'($signed(p8p_ff) >>> 19);
      pqc_ff  <= pqb_ff;
      v1f_ff  <= 64'($signed(q9lo_ff + {q9hi_ff, 32'd0}) >>> 25);
      v2g_ff  <= v2f_ff;
      pqd_ff  <= pqc_ff;
      sum_ff  <= pqd_ff + v1f_ff + v2g_ff;
      pres_ff <= zr_ff[LATENCY-2] ? 32'd0 : pp_in[39:8];
   end

   assign rsp_valid             = vld_ff[LATENCY-1];
   assign rsp_temperature_centi = $signed(tmp_ff[LATENCY-1]);
   assign rsp_pressure_pa       = pres_ff;

endmodule
`default_nettype wire

FILE: rtl/ptc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ptc_checker
   import ptc_pkg::*;
(
   input wire clock,
   input wire reset,
   input wire start,
   input wire busy,
   input wire rsp_valid
);

   a_busy_low: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_fwd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##84 rsp_valid)
      else $error("result missing after transfer");

   a_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 84))
      else $error("result without matching transfer");

   a_reset_quiet: assert property (@(posedge clock) $fell(reset) |-> !rsp_valid)
      else $error("result right after reset");

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (.*);
`default_nettype wire
